// ----- rtl/core/rij_pkg.sv -----
// Package for the rectangle intersection join: stream field layout, function codes,
// walker state encoding and the walker status bundle. No dependencies.
package rij_pkg;

    localparam int FIELD_W     = 32;
    localparam int SLOT_W      = 6;
    localparam int TAG_W       = 16;
    localparam int COUNT_W     = 7;
    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 160;
    localparam int OUT_USED_W  = TAG_W + SLOT_W + 4 * FIELD_W + COUNT_W;

    localparam int IN_SLOT_LSB = 0;
    localparam int IN_RECT_LSB = SLOT_W;
    localparam int IN_TAG_LSB  = SLOT_W + 4 * FIELD_W;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_PROBE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_SPIN = 3'b100
    } t_state;

    typedef struct packed {
        logic busy;
        logic shift;
    } t_walk_stat;

endpackage

// ----- rtl/core/rij_cell.sv -----
// One store cell of the rectangle ring: holds a rectangle, takes a load or the
// neighbor's rectangle on a shift. No package dependencies.
module rij_cell #(
    parameter int RECT_W = 128
) (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic [RECT_W-1:0] i_load_rect,
    input  logic              i_shift,
    input  logic [RECT_W-1:0] i_next_rect,
    output logic [RECT_W-1:0] o_rect
);

    logic [RECT_W-1:0] r_rect;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rect <= i_load_rect;
        end else if (i_shift) begin
            r_rect <= i_next_rect;
        end
    end

    assign o_rect = r_rect;

endmodule

// ----- rtl/core/rij_walker.sv -----
// Probe walker: compares the probe with the head cell of the ring each cycle unless the output stalls,
// holds one hit back to mark the last result, drives the output stream. Uses rij_pkg.
module rij_walker #(
    parameter int STORE_DEPTH = 64,
    parameter int COORD_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [4*COORD_WIDTH-1:0]       i_probe_rect,
    input  logic [rij_pkg::TAG_W-1:0]      i_tag,
    input  logic [rij_pkg::COUNT_W-1:0]    i_count,
    input  logic [4*COORD_WIDTH-1:0]       i_head_rect,
    output rij_pkg::t_walk_stat            o_stat,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // tag_echo, match_index, cut_x_low, cut_y_low, cut_x_high, cut_y_high, hits_so_far
    output logic [rij_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // hit
    output logic                           o_m_axis_tuser,
    output logic                           o_m_axis_tlast
);
    import rij_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int RECT_W = 4 * CW;
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam logic [CNT_W-1:0]   DEPTH_C   = CNT_W'(STORE_DEPTH);
    localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(STORE_DEPTH);

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_j;
    logic [RECT_W-1:0]        r_probe;
    logic [TAG_W-1:0]         r_tag;
    logic [COUNT_W-1:0]       r_hits;

    logic                     r_pend_valid;
    logic [SLOT_W-1:0]        r_pend_idx;
    logic [4*FIELD_W-1:0]     r_pend_cut;
    logic [COUNT_W-1:0]       r_pend_hits;

    logic                     r_out_valid;
    logic [TAG_W-1:0]         r_out_tag;
    logic [SLOT_W-1:0]        r_out_idx;
    logic [4*FIELD_W-1:0]     r_out_cut;
    logic                     r_out_hit;
    logic [COUNT_W-1:0]       r_out_hits;
    logic                     r_out_last;

    logic [CNT_W-1:0]         limit;
    logic [4*FIELD_W-1:0]     cut_ext;
    logic                     overlap;
    logic                     out_free;
    logic                     walking;
    logic                     at_end;
    logic                     stall;
    logic                     step;
    logic                     finish;
    logic                     shift;
    logic                     pend_to_out;

    always_comb begin
        logic signed [CW-1:0] p_lo, s_lo, p_hi, s_hi, c_lo, c_hi;
        overlap = 1'b1;
        cut_ext = '0;
        for (int a = 0; a < 2; a++) begin
            p_lo = $signed(r_probe[a*CW +: CW]);
            s_lo = $signed(i_head_rect[a*CW +: CW]);
            p_hi = $signed(r_probe[(a+2)*CW +: CW]);
            s_hi = $signed(i_head_rect[(a+2)*CW +: CW]);
            c_lo = (p_lo > s_lo) ? p_lo : s_lo;
            c_hi = (p_hi < s_hi) ? p_hi : s_hi;
            if (c_lo > c_hi) begin
                overlap = 1'b0;
            end
            cut_ext[a*FIELD_W +: FIELD_W]     = FIELD_W'(c_lo);
            cut_ext[(a+2)*FIELD_W +: FIELD_W] = FIELD_W'(c_hi);
        end
    end

    assign limit       = (i_count > DEPTH_CNT) ? DEPTH_C : CNT_W'(i_count);
    assign out_free    = !r_out_valid || i_m_axis_tready;
    assign walking     = (r_state == ST_WALK);
    assign at_end      = (r_j == limit);
    assign stall       = walking && !at_end && overlap && r_pend_valid && !out_free;
    assign step        = walking && !at_end && !stall;
    assign finish      = walking && at_end && out_free;
    assign shift       = step || (r_state == ST_SPIN);
    assign pend_to_out = step && overlap && r_pend_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (finish) begin
                    n_state = (r_j == DEPTH_C) ? ST_IDLE : ST_SPIN;
                end
            end
            ST_SPIN: begin
                if (r_j == DEPTH_C - CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_j          <= '0;
            r_hits       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_start) begin
                r_j <= '0;
            end else if (shift) begin
                r_j <= r_j + CNT_W'(1);
            end
            if (i_start) begin
                r_hits <= '0;
            end else if (step && overlap) begin
                r_hits <= r_hits + COUNT_W'(1);
            end
            if (i_start || finish) begin
                r_pend_valid <= 1'b0;
            end else if (step && overlap) begin
                r_pend_valid <= 1'b1;
            end
            if (pend_to_out || finish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_probe <= i_probe_rect;
            r_tag   <= i_tag;
        end
        if (step && overlap) begin
            r_pend_idx  <= SLOT_W'(r_j);
            r_pend_cut  <= cut_ext;
            r_pend_hits <= r_hits + COUNT_W'(1);
        end
        if (pend_to_out || (finish && r_pend_valid)) begin
            r_out_tag  <= r_tag;
            r_out_idx  <= r_pend_idx;
            r_out_cut  <= r_pend_cut;
            r_out_hit  <= 1'b1;
            r_out_hits <= r_pend_hits;
            r_out_last <= finish;
        end else if (finish) begin
            r_out_tag  <= r_tag;
            r_out_idx  <= '0;
            r_out_cut  <= '0;
            r_out_hit  <= 1'b0;
            r_out_hits <= '0;
            r_out_last <= 1'b1;
        end
    end

    assign o_stat.busy     = (r_state != ST_IDLE);
    assign o_stat.shift    = shift;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - OUT_USED_W)'(0), r_out_hits, r_out_cut,
                              r_out_idx, r_out_tag};
    assign o_m_axis_tuser  = r_out_hit;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ----- rtl/core/rectangle_intersection_join.sv -----
// Rectangle intersection join: a ring of STORE_DEPTH cells rotates past the walker.
// Loads write the addressed cell. Probe: input stalled after the transfer for one full ring
// rotation plus output stalls. The first result is registered when the second overlapping
// slot is compared, else when the walk ends.
// Synchronous active-low reset clears the count register and all control; stored
// rectangles are undefined until loaded.
module rectangle_intersection_join #(
    parameter int STORE_DEPTH = 64,
    parameter int COORD_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rij_pkg::COUNT_W-1:0]     i_cfg_wdata,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // slot, x_low, y_low, x_high, y_high, probe_tag
    input  logic [rij_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // func
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tag_echo, match_index, cut_x_low, cut_y_low, cut_x_high, cut_y_high, hits_so_far
    output logic [rij_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // hit
    output logic                            o_m_axis_tuser,
    output logic                            o_m_axis_tlast
);
    import rij_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int RECT_W = 4 * CW;

    logic [COUNT_W-1:0] r_count;
    t_walk_stat         walk_stat;
    logic               in_xfer;
    logic               start;
    logic [SLOT_W-1:0]  in_slot;
    logic [RECT_W-1:0]  in_rect;
    logic [RECT_W-1:0]  cell_rect [STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    assign o_s_axis_tready = !walk_stat.busy;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign start           = in_xfer && (i_s_axis_tuser == FUNC_PROBE);
    assign in_slot         = i_s_axis_tdata[IN_SLOT_LSB +: SLOT_W];

    always_comb begin
        for (int f = 0; f < 4; f++) begin
            in_rect[f*CW +: CW] = i_s_axis_tdata[IN_RECT_LSB + f*FIELD_W +: CW];
        end
    end

    for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
        rij_cell #(
            .RECT_W (RECT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_load      (in_xfer && (i_s_axis_tuser == FUNC_LOAD) &&
                          (in_slot == SLOT_W'(k))),
            .i_load_rect (in_rect),
            .i_shift     (walk_stat.shift),
            .i_next_rect (cell_rect[(k + 1) % STORE_DEPTH]),
            .o_rect      (cell_rect[k])
        );
    end

    rij_walker #(
        .STORE_DEPTH (STORE_DEPTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_walker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_probe_rect    (in_rect),
        .i_tag           (i_s_axis_tdata[IN_TAG_LSB +: TAG_W]),
        .i_count         (r_count),
        .i_head_rect     (cell_rect[0]),
        .o_stat          (walk_stat),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
